// ===== sv/cmt_pkg.sv =====
// Shared types and constants for the minutes/seconds countdown timer.
// No dependencies; imported by cmt_next, countdown_mmss_timer and the testbench.
package cmt_pkg;

  localparam int unsigned MaxMinutes = 99;
  localparam int unsigned MaxSeconds = 59;
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned TopSeconds = MaxMinutes * SecsPerMin + MaxSeconds;

  // Reciprocal of 60 scaled by 2^17, rounded down; one correction step follows.
  localparam int unsigned RecipShift = 17;
  localparam logic [11:0] Recip60    = 12'((1 << RecipShift) / SecsPerMin);

  localparam logic [15:0] SecondTicksReset = 16'd1000;
  localparam logic [15:0] ColonOffReset    = 16'd500;
  localparam logic [15:0] BlinkReset       = 16'd500;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_PAUSE   = 3'd3,
    OP_SET     = 3'd4,
    OP_ADD_SEC = 3'd5,
    OP_ADD_MIN = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_SECOND_TICKS = 2'd0,
    REG_COLON_OFF    = 2'd1,
    REG_PAUSE_BLINK  = 2'd2
  } reg_e;

  typedef struct packed {
    logic [6:0]  minutes;
    logic [5:0]  seconds;
    logic [1:0]  mode;
    logic [15:0] elapsed;
    logic        colon;
    logic        digit;
  } timer_state_t;

  typedef struct packed {
    logic [15:0] second_ticks;
    logic [15:0] colon_off_ticks;
    logic [15:0] pause_blink_ticks;
  } timer_cfg_t;

endpackage

// ===== sv/cmt_next.sv =====
// Next-state logic of the countdown timer for one transaction.
// Depends on cmt_pkg for the state and configuration structs and the codes.
module cmt_next import cmt_pkg::*; (
  input  timer_state_t cur_i,
  input  timer_cfg_t   cfg_i,
  input  logic [2:0]   operation_i,
  input  logic [7:0]   set_minutes_i,
  input  logic [7:0]   set_seconds_i,
  input  logic [13:0]  delta_i,
  output timer_state_t nxt_o,
  output logic         flag_o,
  output logic         finished_o
);

  logic [15:0]        elapsed_inc;
  logic [6:0]         dec_minutes;
  logic [5:0]         dec_seconds;
  logic [12:0]        cur_total;
  logic signed [15:0] sum_total;
  logic [12:0]        clamp_total;
  logic               sec_over;
  logic [24:0]        quot_prod;
  logic [7:0]         quot_est;
  logic [12:0]        rem_est;
  logic [6:0]         add_minutes;
  logic [5:0]         add_seconds;
  logic signed [14:0] min_sum;
  logic [6:0]         min_clamped;
  logic               min_over;

  assign elapsed_inc = (cur_i.elapsed != 16'hFFFF) ? cur_i.elapsed + 16'd1 : cur_i.elapsed;

  // Count down one second, holding at 00:00.
  always_comb begin
    dec_minutes = cur_i.minutes;
    dec_seconds = cur_i.seconds;
    if (cur_i.seconds != 6'd0) begin
      dec_seconds = cur_i.seconds - 6'd1;
    end else if (cur_i.minutes != 7'd0) begin
      dec_minutes = cur_i.minutes - 7'd1;
      dec_seconds = 6'(MaxSeconds);
    end
  end

  // Add seconds: total seconds, clamp, then split by 60 through a reciprocal.
  always_comb begin
    cur_total = ({6'd0, cur_i.minutes} << 6) - ({6'd0, cur_i.minutes} << 2)
                + {7'd0, cur_i.seconds};
    sum_total = $signed({3'b000, cur_total}) + 16'(signed'(delta_i));
    sec_over  = 1'b0;
    if (sum_total < 16'sd0) begin
      clamp_total = 13'd0;
      sec_over    = 1'b1;
    end else if (sum_total > 16'(TopSeconds)) begin
      clamp_total = 13'(TopSeconds);
      sec_over    = 1'b1;
    end else begin
      clamp_total = sum_total[12:0];
    end
    quot_prod = {12'd0, clamp_total} * {13'd0, Recip60};
    quot_est  = quot_prod[24:17];
    rem_est   = clamp_total - 13'({5'd0, quot_est} * 13'(SecsPerMin));
    if (rem_est >= 13'(SecsPerMin)) begin
      add_minutes = 7'(quot_est + 8'd1);
      add_seconds = 6'(rem_est - 13'(SecsPerMin));
    end else begin
      add_minutes = quot_est[6:0];
      add_seconds = rem_est[5:0];
    end
  end

  // Add minutes: clamp the minutes alone.
  always_comb begin
    min_sum  = $signed({8'd0, cur_i.minutes}) + 15'(signed'(delta_i));
    min_over = 1'b0;
    if (min_sum < 15'sd0) begin
      min_clamped = 7'd0;
      min_over    = 1'b1;
    end else if (min_sum > 15'(MaxMinutes)) begin
      min_clamped = 7'(MaxMinutes);
      min_over    = 1'b1;
    end else begin
      min_clamped = min_sum[6:0];
    end
  end

  always_comb begin
    nxt_o      = cur_i;
    flag_o     = 1'b0;
    finished_o = 1'b0;
    unique case (operation_i)
      OP_TICK: begin
        if (cur_i.mode == MODE_RUNNING) begin
          nxt_o.elapsed = elapsed_inc;
          if (elapsed_inc >= cfg_i.colon_off_ticks) begin
            nxt_o.colon = 1'b0;
          end
          if (elapsed_inc >= cfg_i.second_ticks) begin
            nxt_o.elapsed = elapsed_inc - cfg_i.second_ticks;
            nxt_o.colon   = 1'b1;
            nxt_o.minutes = dec_minutes;
            nxt_o.seconds = dec_seconds;
            if (dec_minutes == 7'd0 && dec_seconds == 6'd0) begin
              nxt_o.mode = MODE_STOPPED;
              finished_o = 1'b1;
            end
          end
        end else if (cur_i.mode == MODE_PAUSED) begin
          nxt_o.elapsed = elapsed_inc;
          if (elapsed_inc >= cfg_i.pause_blink_ticks) begin
            nxt_o.elapsed = 16'd0;
            nxt_o.colon   = ~cur_i.colon;
            nxt_o.digit   = ~cur_i.colon;
          end
        end
      end
      OP_START: begin
        nxt_o.mode    = MODE_RUNNING;
        nxt_o.elapsed = 16'd0;
        nxt_o.digit   = 1'b1;
      end
      OP_STOP: begin
        nxt_o.mode  = MODE_STOPPED;
        nxt_o.digit = 1'b1;
      end
      OP_PAUSE: begin
        nxt_o.mode    = MODE_PAUSED;
        nxt_o.elapsed = 16'd0;
      end
      OP_SET: begin
        if (set_minutes_i > 8'(MaxMinutes) || set_seconds_i > 8'(MaxSeconds)) begin
          flag_o = 1'b1;
        end else begin
          nxt_o.minutes = set_minutes_i[6:0];
          nxt_o.seconds = set_seconds_i[5:0];
        end
      end
      OP_ADD_SEC: begin
        nxt_o.minutes = add_minutes;
        nxt_o.seconds = add_seconds;
        flag_o        = sec_over;
      end
      OP_ADD_MIN: begin
        nxt_o.minutes = min_clamped;
        flag_o        = min_over;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ===== sv/countdown_mmss_timer.sv =====
// Top level of the minutes/seconds countdown timer: channels, APB registers,
// input register, timer state and result register. Depends on cmt_pkg and cmt_next.
//
// Usage: each input transaction carries one operation (tick, start, stop,
// pause, set time, add seconds, add minutes) and produces exactly one result
// transaction that shows the time, run mode, colon and digit visibility, and
// the flag and finished pulses that belong to that operation.
// Both channels use valid/stall. An accepted transaction lands in an input
// register; it is applied to the timer state and its result is written to the
// output register as soon as that register is empty or being taken, and
// out_valid_o then holds the result until the receiver takes it.
// One transaction per cycle is sustained while the receiver does not stall: the
// input register moves on whenever the output register is empty or being taken
// in the same cycle. When the receiver stalls, the result holds, the
// input register fills, and only then is in_stall_o raised.
// The three 16-bit registers (second_ticks, colon_off_ticks,
// pause_blink_ticks) sit at byte addresses 0, 4 and 8 of the APB port;
// pready is always high and reads return the stored value.
// Reset clears the time to 00:00, stops the timer, shows colon and digits,
// loads the register defaults (1000, 500, 500) and empties both stages.
module countdown_mmss_timer import cmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  set_minutes_i,
  input  logic [7:0]  set_seconds_i,
  input  logic [13:0] delta_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  minutes_now_o,
  output logic [5:0]  seconds_now_o,
  output logic [1:0]  run_mode_o,
  output logic        colon_shown_o,
  output logic        digits_visible_o,
  output logic        flag_o,
  output logic        finished_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  timer_cfg_t   cfg_q;
  timer_state_t state_q, state_d;
  logic         flag_d, fin_d;

  // Input register.
  logic         in_valid_q;
  logic [2:0]   op_q;
  logic [7:0]   set_min_q;
  logic [7:0]   set_sec_q;
  logic [13:0]  delta_q;

  // Result register.
  logic         out_valid_q;
  timer_state_t res_q;
  logic         res_flag_q;
  logic         res_fin_q;

  logic         in_take;
  logic         advance;
  logic         cfg_write;
  logic [1:0]   reg_index;

  // The input register hands its transaction on when the result register is
  // free or is being emptied in this same cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_comb begin
    unique case (reg_index)
      REG_SECOND_TICKS: prdata = {16'd0, cfg_q.second_ticks};
      REG_COLON_OFF:    prdata = {16'd0, cfg_q.colon_off_ticks};
      REG_PAUSE_BLINK:  prdata = {16'd0, cfg_q.pause_blink_ticks};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.second_ticks      <= SecondTicksReset;
      cfg_q.colon_off_ticks   <= ColonOffReset;
      cfg_q.pause_blink_ticks <= BlinkReset;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_SECOND_TICKS: cfg_q.second_ticks      <= pwdata[15:0];
        REG_COLON_OFF:    cfg_q.colon_off_ticks   <= pwdata[15:0];
        REG_PAUSE_BLINK:  cfg_q.pause_blink_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  cmt_next u_next (
    .cur_i         (state_q),
    .cfg_i         (cfg_q),
    .operation_i   (op_q),
    .set_minutes_i (set_min_q),
    .set_seconds_i (set_sec_q),
    .delta_i       (delta_q),
    .nxt_o         (state_d),
    .flag_o        (flag_d),
    .finished_o    (fin_d)
  );

  // Control state: stage valids and the timer state itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      state_q.minutes <= 7'd0;
      state_q.seconds <= 6'd0;
      state_q.mode    <= MODE_STOPPED;
      state_q.elapsed <= 16'd0;
      state_q.colon   <= 1'b1;
      state_q.digit   <= 1'b1;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= operation_i;
      set_min_q <= set_minutes_i;
      set_sec_q <= set_seconds_i;
      delta_q   <= delta_i;
    end
    if (advance) begin
      res_q      <= state_d;
      res_flag_q <= flag_d;
      res_fin_q  <= fin_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign minutes_now_o    = res_q.minutes;
  assign seconds_now_o    = res_q.seconds;
  assign run_mode_o       = res_q.mode;
  assign colon_shown_o    = res_q.colon;
  assign digits_visible_o = res_q.digit;
  assign flag_o           = res_flag_q;
  assign finished_o       = res_fin_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for countdown_mmss_timer: directed and random operations
// are predicted by a local timer model and every result is checked field by field.
// Depends on cmt_pkg and the countdown_mmss_timer RTL.
module testbench;
  import cmt_pkg::*;

  localparam int CycleLimit     = 600000;
  localparam int DrainCycles    = 8;
  localparam int LongHoldCycles = 60;
  localparam int MaxReports     = 30;

  // Integer copies of the package limits, so that the arithmetic below stays signed.
  localparam int MinuteLen     = SecsPerMin;
  localparam int TimeCeiling   = TopSeconds;
  localparam int MinuteCeiling = MaxMinutes;
  localparam int SecondCeiling = MaxSeconds;
  localparam int TickCeiling   = 65535;

  // The one operation code that the package does not name.
  localparam logic [2:0] OpUnused = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  set_min;
    logic [7:0]  set_sec;
    logic [13:0] delta;
  } timer_cmd_t;

  typedef struct {
    logic [6:0] minutes;
    logic [5:0] seconds;
    mode_e      mode;
    logic       colon;
    logic       digits;
    logic       flag;
    logic       finished;
  } readout_t;

  // Clock, reset and every block input start at a known value.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [2:0]  operation_i   = '0;
  logic [7:0]  set_minutes_i = '0;
  logic [7:0]  set_seconds_i = '0;
  logic [13:0] delta_i       = '0;
  logic        out_stall_i   = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [6:0]  minutes_now_o;
  logic [5:0]  seconds_now_o;
  logic [1:0]  run_mode_o;
  logic        colon_shown_o;
  logic        digits_visible_o;
  logic        flag_o;
  logic        finished_o;
  logic [31:0] prdata;
  logic        pready;

  countdown_mmss_timer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .set_minutes_i    (set_minutes_i),
    .set_seconds_i    (set_seconds_i),
    .delta_i          (delta_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .minutes_now_o    (minutes_now_o),
    .seconds_now_o    (seconds_now_o),
    .run_mode_o       (run_mode_o),
    .colon_shown_o    (colon_shown_o),
    .digits_visible_o (digits_visible_o),
    .flag_o           (flag_o),
    .finished_o       (finished_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Operations waiting to be offered, and the readouts that accepted operations owe.
  timer_cmd_t pending_cmds[$];
  readout_t   expected_readouts[$];

  int items_offered  = 0;
  int items_accepted = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int zero_reached   = 0;
  int flags_raised   = 0;
  int settings_used  = 0;
  bit idle_on        = 1'b1;
  int hold_asked     = 0;
  int hold_served    = 0;

  // Local copy of the timer: time, run mode, tick count and the two blink phases,
  // plus the three registers. It is advanced once per accepted transaction.
  int    cnt_minutes      = 0;
  int    cnt_seconds      = 0;
  int    tick_count       = 0;
  mode_e cur_mode         = MODE_STOPPED;
  logic  colon_on         = 1'b1;
  logic  digits_on        = 1'b1;
  int    ticks_per_second = SecondTicksReset;
  int    colon_hide_at    = ColonOffReset;
  int    blink_period     = BlinkReset;

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Moves the time by a signed number of seconds, clamped to 00:00..99:59.
  // Returns 1 when the clamp was needed.
  function automatic bit shift_time(int secs);
    int total;
    bit clamped;
    total   = cnt_minutes * MinuteLen + cnt_seconds + secs;
    clamped = 1'b0;
    if (total < 0) begin
      total   = 0;
      clamped = 1'b1;
    end else if (total > TimeCeiling) begin
      total   = TimeCeiling;
      clamped = 1'b1;
    end
    cnt_minutes = total / MinuteLen;
    cnt_seconds = total % MinuteLen;
    return clamped;
  endfunction

  // Applies one operation to the local timer and returns the readout it must show.
  function automatic readout_t apply_operation(timer_cmd_t cmd);
    readout_t r;
    int       amount;
    logic     flag;
    logic     done;
    amount = int'($signed(cmd.delta));
    flag   = 1'b0;
    done   = 1'b0;
    case (cmd.op)
      OP_TICK: begin
        if (cur_mode == MODE_RUNNING) begin
          // The tick count saturates before either comparison; one second at most per tick.
          if (tick_count < TickCeiling) tick_count++;
          if (tick_count >= colon_hide_at) colon_on = 1'b0;
          if (tick_count >= ticks_per_second) begin
            tick_count -= ticks_per_second;
            colon_on = 1'b1;
            void'(shift_time(-1));
            if (cnt_minutes == 0 && cnt_seconds == 0) begin
              cur_mode = MODE_STOPPED;
              done     = 1'b1;
            end
          end
        end else if (cur_mode == MODE_PAUSED) begin
          if (tick_count < TickCeiling) tick_count++;
          if (tick_count >= blink_period) begin
            tick_count = 0;
            colon_on   = ~colon_on;
            digits_on  = colon_on;
          end
        end
      end
      OP_START: begin
        cur_mode   = MODE_RUNNING;
        tick_count = 0;
        digits_on  = 1'b1;
      end
      OP_STOP: begin
        cur_mode  = MODE_STOPPED;
        digits_on = 1'b1;
      end
      OP_PAUSE: begin
        cur_mode   = MODE_PAUSED;
        tick_count = 0;
      end
      OP_SET: begin
        if (cmd.set_min > MinuteCeiling || cmd.set_sec > SecondCeiling) begin
          flag = 1'b1;
        end else begin
          cnt_minutes = cmd.set_min;
          cnt_seconds = cmd.set_sec;
        end
      end
      OP_ADD_SEC: flag = shift_time(amount);
      OP_ADD_MIN: begin
        // Only the minutes move here; the seconds are left alone.
        cnt_minutes += amount;
        if (cnt_minutes < 0) begin
          cnt_minutes = 0;
          flag        = 1'b1;
        end else if (cnt_minutes > MinuteCeiling) begin
          cnt_minutes = MinuteCeiling;
          flag        = 1'b1;
        end
      end
      default: ;
    endcase
    r.minutes  = 7'(cnt_minutes);
    r.seconds  = 6'(cnt_seconds);
    r.mode     = cur_mode;
    r.colon    = colon_on;
    r.digits   = digits_on;
    r.flag     = flag;
    r.finished = done;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sender: offers the next pending operation at the falling edge and holds it,
  // payload unchanged, until the monitor has seen it accepted.
  int gap_left = 0;
  always @(negedge clk_i) begin
    timer_cmd_t next_cmd;
    if (rst_ni && items_offered == items_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        operation_i   <= next_cmd.op;
        set_minutes_i <= next_cmd.set_min;
        set_seconds_i <= next_cmd.set_sec;
        delta_i       <= next_cmd.delta;
        items_offered++;
        gap_left = idle_on ? pick_gap() : 0;
      end
    end
    in_valid_i <= (items_offered != items_accepted);
  end

  // Receiver: random stall bursts separated by random flowing stretches, plus a
  // long hold-off on request that is counted out here.
  int stall_left = 0;
  int flow_left  = 0;
  int hold_left  = 0;
  always @(negedge clk_i) begin
    logic stall_next;
    if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      stall_next = 1'b0;
    end else begin
      stall_next = 1'b0;
      if (idle_on) begin
        stall_left = pick_gap();
        flow_left  = $urandom_range(0, 12);
      end
    end
    out_stall_i <= stall_next;
  end

  // Monitor: at each rising edge, checks an accepted result against the oldest
  // expectation, then predicts the result of an accepted operation.
  always @(posedge clk_i) begin
    readout_t   want;
    timer_cmd_t taken;
    cycle_count++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readouts.size() == 0) begin
          mismatches++;
          $error("result transaction with no operation outstanding");
        end else begin
          want = expected_readouts.pop_front();
          check_field("minutes_now", want.minutes, minutes_now_o);
          check_field("seconds_now", want.seconds, seconds_now_o);
          check_field("run_mode", want.mode, run_mode_o);
          check_field("colon_shown", want.colon, colon_shown_o);
          check_field("digits_visible", want.digits, digits_visible_o);
          check_field("flag", want.flag, flag_o);
          check_field("finished", want.finished, finished_o);
          results_seen++;
          zero_reached += want.finished;
          flags_raised += want.flag;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        taken = '{operation_i, set_minutes_i, set_seconds_i, delta_i};
        expected_readouts.push_back(apply_operation(taken));
        items_accepted++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, expected_readouts.size());
    $display("FAILED: results differ");
    $finish;
  end

  task automatic queue_cmd(logic [2:0] op, logic [7:0] sm, logic [7:0] ss, logic [13:0] d);
    pending_cmds.push_back('{op, sm, ss, d});
  endtask

  // An operation whose unused fields carry random noise.
  task automatic queue_op(logic [2:0] op);
    queue_cmd(op, 8'($urandom), 8'($urandom), 14'($urandom));
  endtask

  // Waits until nothing is in flight, then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || items_offered != items_accepted ||
           expected_readouts.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write, then a read back of the same register.
  task automatic write_register(reg_e idx, logic [15:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'h0000, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    check_field("prdata", {16'h0000, value}, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_SECOND_TICKS: ticks_per_second = value;
      REG_COLON_OFF:    colon_hide_at    = value;
      REG_PAUSE_BLINK:  blink_period     = value;
      default: ;
    endcase
  endtask

  // Drains the block, loads a new register setting and picks the idling style.
  task automatic begin_phase(logic [15:0] st, logic [15:0] co, logic [15:0] bl, bit idle);
    wait_idle();
    write_register(REG_SECOND_TICKS, st);
    write_register(REG_COLON_OFF, co);
    write_register(REG_PAUSE_BLINK, bl);
    @(posedge clk_i);
    settings_used++;
    idle_on = idle;
  endtask

  // Random operations. Short countdowns from small times keep the timer moving
  // through running, expiry and blinking; the rest is single operations with
  // mostly sensible and sometimes arbitrary field values.
  task automatic queue_random(int count);
    int          added;
    int          roll;
    int          len;
    logic [13:0] amount;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        len = $urandom_range(3, 30);
        queue_cmd(OP_SET, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 6)), 14'($urandom));
        queue_op(OP_START);
        repeat (len) queue_op(OP_TICK);
        added += len + 2;
      end else begin
        if (roll < 58) begin
          queue_op(OP_TICK);
        end else if (roll < 64) begin
          queue_op(OP_START);
        end else if (roll < 67) begin
          queue_op(OP_STOP);
        end else if (roll < 72) begin
          queue_op(OP_PAUSE);
        end else if (roll < 80) begin
          roll = $urandom_range(0, 3);
          if (roll < 2)
            queue_cmd(OP_SET, 8'($urandom_range(0, 2)), 8'($urandom_range(0, 10)),
                      14'($urandom));
          else if (roll == 2)
            queue_cmd(OP_SET, 8'($urandom_range(0, 99)), 8'($urandom_range(0, 59)),
                      14'($urandom));
          else
            queue_op(OP_SET);
        end else if (roll < 88) begin
          roll = $urandom_range(0, 9);
          if (roll < 5)      amount = 14'($urandom_range(0, 40) - 20);
          else if (roll < 7) amount = 14'(-60 * $urandom_range(1, 3));
          else               amount = 14'($urandom);
          queue_cmd(OP_ADD_SEC, 8'($urandom), 8'($urandom), amount);
        end else if (roll < 95) begin
          if ($urandom_range(0, 9) < 6) amount = 14'($urandom_range(0, 6) - 3);
          else                          amount = 14'($urandom);
          queue_cmd(OP_ADD_MIN, 8'($urandom), 8'($urandom), amount);
        end else if (roll < 97) begin
          queue_op(OpUnused);
        end else begin
          queue_op(3'($urandom));
        end
        added++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // Arithmetic corners under the reset register values, timer stopped.
    queue_cmd(OP_SET, 8'd99, 8'd59, 14'd0);
    queue_cmd(OP_ADD_SEC, 8'd0, 8'd0, 14'd1);
    queue_cmd(OP_SET, 8'd100, 8'd0, 14'd0);
    queue_cmd(OP_SET, 8'd0, 8'd60, 14'd0);
    queue_cmd(OP_SET, 8'd255, 8'd255, 14'h3FFF);
    queue_cmd(OP_SET, 8'd1, 8'd0, 14'd0);
    // A negative add of a whole minute must land exactly on 00:00.
    queue_cmd(OP_ADD_SEC, 8'd0, 8'd0, 14'(-60));
    queue_cmd(OP_ADD_SEC, 8'd0, 8'd0, 14'h2000);
    queue_cmd(OP_ADD_SEC, 8'd0, 8'd0, 14'h1FFF);
    queue_cmd(OP_ADD_MIN, 8'd0, 8'd0, 14'h2000);
    queue_cmd(OP_ADD_MIN, 8'd0, 8'd0, 14'h1FFF);
    queue_cmd(OpUnused, 8'hFF, 8'hFF, 14'h3FFF);
    queue_cmd(OP_TICK, 8'd0, 8'd0, 14'd0);

    // Short periods: start at 00:00, colon hiding, pause blinking, stop.
    begin_phase(16'd3, 16'd2, 16'd2, 1'b1);
    queue_cmd(OP_SET, 8'd0, 8'd0, 14'd0);
    queue_op(OP_START);
    repeat (3) queue_op(OP_TICK);
    queue_cmd(OP_SET, 8'd0, 8'd2, 14'd0);
    queue_op(OP_START);
    repeat (2) queue_op(OP_TICK);
    queue_op(OP_PAUSE);
    repeat (4) queue_op(OP_TICK);
    queue_op(OP_STOP);

    // Random traffic. The receiver holds off long enough to back the block up
    // while the sender keeps offering; then the sender waits for every result.
    begin_phase(16'd3, 16'd2, 16'd2, 1'b1);
    queue_random(60);
    hold_asked++;
    wait_idle();
    queue_random(60);

    begin_phase(16'd1, 16'd1, 16'd1, 1'b0);
    queue_random(120);

    // Largest periods; the phase ends running with a sizable tick count.
    begin_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_random(80);
    queue_cmd(OP_SET, 8'd5, 8'd0, 14'd0);
    queue_op(OP_START);
    repeat (100) queue_op(OP_TICK);

    // The second length drops below the running tick count, so each tick may
    // end only one second.
    begin_phase(16'd2, 16'd1, 16'd3, 1'b1);
    repeat (20) queue_op(OP_TICK);
    queue_random(120);

    // Zero periods: a second on every tick, the colon always hidden first.
    begin_phase(16'd0, 16'd0, 16'd0, 1'b1);
    queue_random(120);

    // Colon threshold past the end of a second: while running, the colon never hides.
    begin_phase(16'd5, 16'd7, 16'd4, 1'b1);
    queue_random(120);

    // Longest second with the shortest colon delay: the colon hides at once.
    begin_phase(16'hFFFF, 16'd1, 16'd1, 1'b1);
    repeat (3) queue_op(OP_TICK);
    queue_op(OP_STOP);

    wait_idle();
    $display("Checked %0d results over %0d register settings: %0d countdowns hit zero,",
             results_seen, settings_used + 1, zero_reached);
    $display("%0d flagged adds or sets, %0d mismatches.", flags_raised, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
